// ----- design/jst_pkg.sv -----
// jst_pkg: shared widths, op codes, job states and register indexes
// for the job status table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jst_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [2:0] OP_CREATE   = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_COMPLETE = 3'd2;
	localparam logic [2:0] OP_FAIL     = 3'd3;
	localparam logic [2:0] OP_SNAPSHOT = 3'd4;
	localparam logic [2:0] OP_CLEANUP  = 3'd5;

	localparam logic [1:0] ST_QUEUED     = 2'd0;
	localparam logic [1:0] ST_PROCESSING = 2'd1;
	localparam logic [1:0] ST_COMPLETED  = 2'd2;
	localparam logic [1:0] ST_FAILED     = 2'd3;

	localparam logic [1:0] REG_MAX_JOBS = 2'd0;
	localparam logic [1:0] REG_TTL      = 2'd1;
	localparam logic [1:0] REG_WORKER   = 2'd2;

	// one stored job record
	typedef struct packed {
		logic [63:0] id;
		logic [1:0]  state;
		logic [3:0]  kind;
		logic [31:0] created_sec;
		logic [31:0] started_sec;
		logic [31:0] started_ms;
		logic [31:0] completed_sec;
		logic [31:0] dur_ms;
		logic [31:0] files;
		logic [15:0] error;
	} rec_t;

	localparam int RecW = $bits(rec_t);
endpackage
`default_nettype wire

// ----- design/jst_ram.sv -----
// jst_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module jst_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/job_status_table.sv -----
// job_status_table: top level of the job record table; records live in
// jst_ram, valid bits in flip-flops. Depends on jst_pkg and jst_ram.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------
//   request | start / busy        | operation, job_id, purge_kind, ...
//   result  | done (one cycle)    | ok, result_id, job_state, ... elapsed_ms
//   config  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A lookup (start, complete, fail, snapshot) scans the RAM one entry a
// cycle until the id matches or every entry is read. Cleanup sweeps all
// entries. Create sweeps first when the count has reached the job limit,
// then allocates a free slot. Job id zero on a lookup and unknown ops
// answer without busy. The result strobes in the same cycle busy drops.
// The single RAM read port sets the scan rate. Reset clears valid bits, count
// and sequence counter at once; no clearing pass. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module job_status_table import jst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] job_id,
	input  wire logic [3:0]  purge_kind,
	input  wire logic [31:0] file_total,
	input  wire logic [15:0] err_num,
	input  wire logic [31:0] now_sec,
	input  wire logic [31:0] now_msec,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic             ok,
	output logic [63:0]      result_id,
	output logic [1:0]       job_state,
	output logic [3:0]       kind,
	output logic [31:0]      file_count,
	output logic [15:0]      fault_code,
	output logic [31:0]      created_sec,
	output logic [31:0]      started_sec,
	output logic [31:0]      started_ms,
	output logic [31:0]      completed_sec,
	output logic [31:0]      elapsed_ms
);
	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SWEEP, S_ALLOC, S_MOD, S_RPT, S_DIV
	} state_t;

	state_t state_q;
	logic [6:0]  max_jobs_q;
	logic [15:0] ttl_q;
	logic [9:0]  worker_q;
	logic [TableDepth-1:0] valid_q;
	logic [CntW-1:0] count_q;
	logic [11:0] seq_q;

	// latched request
	logic [2:0]  op_q;
	logic [63:0] jid_q;
	logic [3:0]  kind_q;
	logic [31:0] files_q;
	logic [15:0] err_q;
	logic [31:0] nsec_q;
	logic [31:0] nms_q;
	logic [31:0] qest_q;
	logic [9:0]  msmod_q;

	// scan address issued and the one whose data returns this cycle
	logic [CntW-1:0] addr_q;
	logic [IdxW-1:0] prev_q;
	logic            pend_q;
	logic            sweep_create_q;
	logic [IdxW-1:0] hit_q;
	rec_t            rec_q;

	logic            we;
	logic [IdxW-1:0] waddr;
	rec_t            wrec, rrec;
	logic [IdxW-1:0] raddr;

	jst_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrec),
		.raddr(raddr), .rdata(rrec)
	);

	assign raddr = addr_q[IdxW-1:0];
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;

	logic [CntW-1:0] limit;
	always_comb begin
		if (max_jobs_q == 7'd0 || max_jobs_q > 7'(TableDepth))
			limit = CntW'(TableDepth);
		else
			limit = CntW'(max_jobs_q);
	end

	// first free slot
	logic [IdxW-1:0] free_idx;
	logic            free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = TableDepth-1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IdxW'(i);
				free_any = 1'b1;
			end
		end
	end

	// expiry test on the returning record, signed 33-bit difference
	logic [32:0] age;
	logic        expired;
	assign age = {1'b0, nsec_q} - {1'b0, rrec.completed_sec};
	assign expired = valid_q[prev_q] &&
		(rrec.state == ST_COMPLETED || rrec.state == ST_FAILED) &&
		!age[32] && (age[31:0] > {16'd0, ttl_q});

	// msec mod 1000: latch a floor reciprocal quotient, then one compare and
	// subtract on the remainder in the following cycle
	logic [31:0] q_est;
	logic [63:0] prod;
	logic [31:0] rem_raw;
	assign prod = 64'(now_msec) * 64'd4294967;
	assign q_est = prod[63:32];
	assign rem_raw = nms_q - qest_q * 32'd1000;

	// modify stage
	rec_t mod;
	logic [31:0] dur;
	always_comb begin
		mod = rec_q;
		dur = '0;
		case (op_q)
			OP_START: begin
				if (rec_q.state == ST_QUEUED) begin
					mod.state = ST_PROCESSING;
					mod.started_sec = nsec_q;
					mod.started_ms = nms_q;
				end
			end
			OP_COMPLETE, OP_FAIL: begin
				if (rec_q.state == ST_QUEUED || rec_q.state == ST_PROCESSING) begin
					if ((op_q == OP_COMPLETE) ? (rec_q.started_sec == 32'd0)
						: (rec_q.started_ms == 32'd0)) begin
						mod.started_sec = nsec_q;
						mod.started_ms = nms_q;
					end
					dur = (nms_q >= mod.started_ms) ? nms_q - mod.started_ms : 32'd0;
					mod.completed_sec = nsec_q;
					mod.dur_ms = dur;
					if (op_q == OP_COMPLETE) begin
						mod.state = ST_COMPLETED;
						mod.files = files_q;
					end else begin
						mod.state = ST_FAILED;
						mod.error = err_q;
					end
				end
			end
			default: ;
		endcase
	end

	// new record for create
	rec_t newrec;
	logic [63:0] nid;
	always_comb begin
		nid = {nsec_q, msmod_q, worker_q, seq_q};
		if (nid == 64'd0) nid = 64'd1;
		newrec = '0;
		newrec.id = nid;
		newrec.state = ST_QUEUED;
		newrec.kind = kind_q;
		newrec.created_sec = nsec_q;
	end

	assign we = (state_q == S_ALLOC && free_any) || (state_q == S_MOD);
	assign waddr = (state_q == S_ALLOC) ? free_idx : hit_q;
	assign wrec = (state_q == S_ALLOC) ? newrec : mod;

	function automatic logic [31:0] live_el(rec_t r, logic [31:0] nm);
		if (r.state == ST_COMPLETED || r.state == ST_FAILED) return r.dur_ms;
		if (r.started_ms != 32'd0 && nm >= r.started_ms) return nm - r.started_ms;
		return 32'd0;
	endfunction

	task automatic put_rec(input rec_t r);
		ok <= 1'b1;
		result_id <= r.id;
		job_state <= r.state;
		kind <= r.kind;
		file_count <= r.files;
		fault_code <= r.error;
		created_sec <= r.created_sec;
		started_sec <= r.started_sec;
		started_ms <= r.started_ms;
		completed_sec <= r.completed_sec;
		elapsed_ms <= live_el(r, nms_q);
	endtask

	task automatic put_zero(input logic okv, input logic [63:0] idv);
		ok <= okv;
		result_id <= idv;
		job_state <= '0;
		kind <= '0;
		file_count <= '0;
		fault_code <= '0;
		created_sec <= '0;
		started_sec <= '0;
		started_ms <= '0;
		completed_sec <= '0;
		elapsed_ms <= '0;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_jobs_q <= 7'd64;
			ttl_q <= 16'd3600;
			worker_q <= '0;
			valid_q <= '0;
			count_q <= '0;
			seq_q <= '0;
			done <= 1'b0;
			pend_q <= 1'b0;
			addr_q <= '0;
			sweep_create_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MAX_JOBS: max_jobs_q <= cfg_data[6:0];
					REG_TTL:      ttl_q <= cfg_data;
					REG_WORKER:   worker_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= operation;
						jid_q <= job_id;
						kind_q <= purge_kind;
						files_q <= file_total;
						err_q <= err_num;
						nsec_q <= now_sec;
						nms_q <= now_msec;
						qest_q <= q_est;
						addr_q <= '0;
						pend_q <= 1'b0;
						case (operation)
							OP_CREATE: begin
								state_q <= S_DIV;
							end
							OP_CLEANUP: begin
								sweep_create_q <= 1'b0;
								state_q <= S_SWEEP;
							end
							OP_START, OP_COMPLETE, OP_FAIL, OP_SNAPSHOT: begin
								if (job_id == 64'd0) begin
									put_zero(1'b0, job_id);
									done <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								put_zero(1'b0, 64'd0);
								done <= 1'b1;
							end
						endcase
					end
				end
				S_DIV: begin
					// reciprocal estimate is low by at most one
					if (rem_raw >= 32'd1000)
						msmod_q <= 10'(rem_raw - 32'd1000);
					else
						msmod_q <= 10'(rem_raw);
					if (count_q >= limit) begin
						sweep_create_q <= 1'b1;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_SCAN: begin
					// data for prev_q arrives while the next address is issued
					prev_q <= addr_q[IdxW-1:0];
					addr_q <= addr_q + 1'b1;
					pend_q <= (addr_q < CntW'(TableDepth));
					if (pend_q && valid_q[prev_q] && rrec.id == jid_q) begin
						hit_q <= prev_q;
						rec_q <= rrec;
						state_q <= (op_q == OP_SNAPSHOT) ? S_RPT : S_MOD;
					end else if (pend_q && addr_q >= CntW'(TableDepth)) begin
						put_zero(1'b0, jid_q);
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					logic [CntW-1:0] cnt_n;
					cnt_n = count_q;
					prev_q <= addr_q[IdxW-1:0];
					addr_q <= addr_q + 1'b1;
					pend_q <= (addr_q < CntW'(TableDepth));
					if (pend_q && expired) begin
						valid_q[prev_q] <= 1'b0;
						if (count_q != '0) cnt_n = count_q - 1'b1;
						count_q <= cnt_n;
					end
					if (pend_q && addr_q >= CntW'(TableDepth)) begin
						if (sweep_create_q) begin
							if (cnt_n >= limit) begin
								put_zero(1'b0, 64'd0);
								done <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_ALLOC;
							end
						end else begin
							put_zero(1'b1, 64'd0);
							done <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_ALLOC: begin
					done <= 1'b1;
					state_q <= S_IDLE;
					if (free_any) begin
						valid_q[free_idx] <= 1'b1;
						count_q <= count_q + 1'b1;
						seq_q <= seq_q + 1'b1;
						put_rec(newrec);
					end else begin
						put_zero(1'b0, 64'd0);
					end
				end
				S_MOD: begin
					put_rec(mod);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RPT: begin
					put_rec(rec_q);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/jst_checker.sv -----
// jst_checker: port-level assertions for job_status_table, bound to it.
// Depends on job_status_table ports only.
`timescale 1ns / 1ps
`default_nettype none
module jst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_ready
);
	// a result leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	// config is never taken while busy
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready) else $error("cfg ready while busy");
	// accepted request either answers now or raises busy
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("request lost");
	// a result only follows an accepted request or a busy cycle
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start)) else $error("spurious done");
endmodule

bind job_status_table jst_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cfg_ready(cfg_ready)
);
`default_nettype wire
